FILE: design/tccm_pkg.sv
package tccm_pkg;

   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 64;
   localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

   localparam int CMD_DEPTH   = 2;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_LOCATE = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_INDEX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_INDEX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT = 3'd4;

   localparam logic [7:0] RESET_COLUMN_COUNT = 8'd80;
   localparam logic [6:0] RESET_ROW_COUNT    = 7'd25;
   localparam logic [7:0] RESET_FG_INDEX     = 8'd15;
   localparam logic [7:0] RESET_BG_INDEX     = 8'd0;
   localparam logic [1:0] RESET_PIXEL_FORMAT = 2'd3;

   localparam logic [1:0] PIX_RGB332 = 2'd0;
   localparam logic [1:0] PIX_RGB555 = 2'd1;
   localparam logic [1:0] PIX_RGB565 = 2'd2;
   localparam logic [1:0] PIX_RGB888 = 2'd3;

   localparam logic [23:0] PALETTE [16] = '{
      24'h000000, 24'h0000ff, 24'h00ff00, 24'h00ffff,
      24'hff0000, 24'hff00ff, 24'h808000, 24'hc0c0c0,
      24'h808080, 24'h000080, 24'hD9C4D1, 24'h96A48E,
      24'h800000, 24'h800080, 24'hffff00, 24'hffffff
   };

   typedef struct packed {
      logic        cell_written;
      logic [6:0]  cell_column;
      logic [5:0]  cell_row;
      logic [7:0]  cell_char;
      logic [3:0]  cell_color_index;
      logic [23:0] fg_pixel;
      logic [23:0] bg_pixel;
      logic [6:0]  cursor_column;
      logic [5:0]  cursor_row;
      logic        scrolled;
   } rsp_type;

   typedef struct packed {
      logic              do_write;
      logic              do_read;
      logic              do_scroll;
      logic              do_clear;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        cols;
      logic [LEN_W-1:0]  len;
      rsp_type           rsp;
   } cmd_type;

   function automatic logic [23:0] pack_pixel(logic [3:0] idx, logic [1:0] fmt);
      logic [23:0] c;
      logic [23:0] p;
      c = PALETTE[idx];
      case (fmt)
         PIX_RGB332: p = {16'd0, c[23:21], c[12:11], 1'b0, c[1:0]};
         PIX_RGB555: p = {9'd0, c[23:19], c[15:11], c[7:3]};
         PIX_RGB565: p = {8'd0, c[23:19], c[15:10], c[7:3]};
         default:    p = c;
      endcase
      return p;
   endfunction

endpackage

FILE: design/text_console_cell_manager_core.sv
// put, locate, read and a newline without scroll: queue, then back-end states idle
// (fetch), start (store access), done (result load, waits for a free result slot);
// clear adds a sweep of the cols*rows cells, scroll a copy of each row one row up
// and a blank of the last row; a 2-entry command queue lets the front keep accepting
// reset: synchronous; afterwards a pass over all 8192 entries zeroes both stores with
// req_full high, configuration writes are taken throughout
module text_console_cell_manager_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [1:0]                     req_op,
   input  logic [7:0]                     req_char_code,
   input  logic [7:0]                     req_target_column,
   input  logic [6:0]                     req_target_row,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic                           rsp_cell_written,
   output logic [6:0]                     rsp_cell_column,
   output logic [5:0]                     rsp_cell_row,
   output logic [7:0]                     rsp_cell_char,
   output logic [3:0]                     rsp_cell_color_index,
   output logic [23:0]                    rsp_fg_pixel,
   output logic [23:0]                    rsp_bg_pixel,
   output logic [6:0]                     rsp_cursor_column,
   output logic [5:0]                     rsp_cursor_row,
   output logic                           rsp_scrolled,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tccm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_data
);

   tccm_pkg::cmd_type front_cmd;
   tccm_pkg::cmd_type queue_head;
   tccm_pkg::rsp_type back_rsp;
   logic              queue_full;
   logic              queue_empty;
   logic              queue_pop;
   logic              init_busy;
   logic              accept;

   assign req_full = queue_full || init_busy;
   assign accept   = req_push && !req_full;

   tccm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_op            (req_op),
      .req_char_code     (req_char_code),
      .req_target_column (req_target_column),
      .req_target_row    (req_target_row),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (front_cmd)
   );

   tccm_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .pop      (queue_pop),
      .head     (queue_head),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   tccm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (queue_empty),
      .cmd_head  (queue_head),
      .cmd_pop   (queue_pop),
      .init_busy (init_busy),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (back_rsp)
   );

   assign rsp_cell_written     = back_rsp.cell_written;
   assign rsp_cell_column      = back_rsp.cell_column;
   assign rsp_cell_row         = back_rsp.cell_row;
   assign rsp_cell_char        = back_rsp.cell_char;
   assign rsp_cell_color_index = back_rsp.cell_color_index;
   assign rsp_fg_pixel         = back_rsp.fg_pixel;
   assign rsp_bg_pixel         = back_rsp.bg_pixel;
   assign rsp_cursor_column    = back_rsp.cursor_column;
   assign rsp_cursor_row       = back_rsp.cursor_row;
   assign rsp_scrolled         = back_rsp.scrolled;

endmodule

FILE: design/tccm_front.sv
module tccm_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [1:0]                       req_op,
   input  logic [7:0]                       req_char_code,
   input  logic [7:0]                       req_target_column,
   input  logic [6:0]                       req_target_row,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tccm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                       csr_data,
   output tccm_pkg::cmd_type                cmd
);

   logic [7:0] column_count_ff;
   logic [6:0] row_count_ff;
   logic [7:0] fg_index_ff;
   logic [7:0] bg_index_ff;
   logic [1:0] pixel_format_ff;
   logic [6:0] cursor_col_ff;
   logic [5:0] cursor_row_ff;

   logic [7:0] cols;
   logic [6:0] rows;
   logic [6:0] cur_col;
   logic [5:0] cur_row;
   logic [6:0] tgt_col;
   logic [5:0] tgt_row;
   logic [3:0] fgi;
   logic [3:0] bgi;
   logic [7:0] put_col_next;
   logic [6:0] put_row_next;
   logic [6:0] mul_col;
   logic [5:0] mul_row;
   logic [13:0] prod;
   logic [tccm_pkg::LEN_W-1:0] len;
   logic [6:0] cursor_col_in;
   logic [5:0] cursor_row_in;
   logic new_line;
   tccm_pkg::op_type op;

   assign csr_ready = 1'b1;
   assign op = tccm_pkg::op_type'(req_op);

   always_comb begin
      cols = column_count_ff;
      if (column_count_ff == 8'd0) begin
         cols = 8'd1;
      end else if (column_count_ff > 8'(tccm_pkg::MAX_COLUMNS)) begin
         cols = 8'(tccm_pkg::MAX_COLUMNS);
      end
      rows = row_count_ff;
      if (row_count_ff == 7'd0) begin
         rows = 7'd1;
      end else if (row_count_ff > 7'(tccm_pkg::MAX_ROWS)) begin
         rows = 7'(tccm_pkg::MAX_ROWS);
      end

      // cursor falls back inside the screen if the dimensions shrank
      cur_col = ({1'b0, cursor_col_ff} >= cols) ? 7'(cols - 8'd1) : cursor_col_ff;
      cur_row = ({1'b0, cursor_row_ff} >= rows) ? 6'(rows - 7'd1) : cursor_row_ff;
      tgt_col = (req_target_column >= cols) ? 7'(cols - 8'd1) : req_target_column[6:0];
      tgt_row = (req_target_row >= rows) ? 6'(rows - 7'd1) : req_target_row[5:0];
      fgi = (fg_index_ff > 8'd15) ? 4'd15 : fg_index_ff[3:0];
      bgi = (bg_index_ff > 8'd15) ? 4'd15 : bg_index_ff[3:0];

      put_col_next = {1'b0, cur_col} + 8'd1;
      put_row_next = {1'b0, cur_row} + 7'd1;

      mul_col = (op == tccm_pkg::OP_READ) ? tgt_col : cur_col;
      mul_row = (op == tccm_pkg::OP_READ) ? tgt_row : cur_row;
      prod = {8'd0, mul_row} * {6'd0, cols};
      len = tccm_pkg::LEN_W'({7'd0, rows} * {6'd0, cols});

      cmd = '0;
      cmd.addr = tccm_pkg::ADDR_W'(prod + {7'd0, mul_col});
      cmd.cols = cols;
      cmd.len = len;
      cmd.rsp.fg_pixel = tccm_pkg::pack_pixel(fgi, pixel_format_ff);
      cmd.rsp.bg_pixel = tccm_pkg::pack_pixel(bgi, pixel_format_ff);

      cursor_col_in = cur_col;
      cursor_row_in = cur_row;
      new_line = 1'b0;

      unique case (op)
         tccm_pkg::OP_PUT: begin
            if (req_char_code == tccm_pkg::NEWLINE_CODE) begin
               new_line = 1'b1;
            end else begin
               cmd.do_write = 1'b1;
               cmd.rsp.cell_written = 1'b1;
               cmd.rsp.cell_column = cur_col;
               cmd.rsp.cell_row = cur_row;
               cmd.rsp.cell_char = req_char_code;
               cmd.rsp.cell_color_index = fgi;
               cursor_col_in = put_col_next[6:0];
               if (put_col_next >= cols) begin
                  new_line = 1'b1;
               end
            end
            if (new_line) begin
               cursor_col_in = '0;
               if (put_row_next >= rows) begin
                  cursor_row_in = 6'(rows - 7'd1);
                  cmd.do_scroll = 1'b1;
                  cmd.rsp.scrolled = 1'b1;
               end else begin
                  cursor_row_in = put_row_next[5:0];
               end
            end
         end
         tccm_pkg::OP_LOCATE: begin
            cursor_col_in = tgt_col;
            cursor_row_in = tgt_row;
         end
         tccm_pkg::OP_READ: begin
            cmd.do_read = 1'b1;
            cmd.rsp.cell_column = tgt_col;
            cmd.rsp.cell_row = tgt_row;
         end
         tccm_pkg::OP_CLEAR: begin
            cmd.do_clear = 1'b1;
         end
         default: begin
         end
      endcase

      cmd.rsp.cursor_column = cursor_col_in;
      cmd.rsp.cursor_row = cursor_row_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= tccm_pkg::RESET_COLUMN_COUNT;
         row_count_ff    <= tccm_pkg::RESET_ROW_COUNT;
         fg_index_ff     <= tccm_pkg::RESET_FG_INDEX;
         bg_index_ff     <= tccm_pkg::RESET_BG_INDEX;
         pixel_format_ff <= tccm_pkg::RESET_PIXEL_FORMAT;
         cursor_col_ff   <= '0;
         cursor_row_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tccm_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_data;
               tccm_pkg::CSR_ROW_COUNT:    row_count_ff <= csr_data[6:0];
               tccm_pkg::CSR_FG_INDEX:     fg_index_ff <= csr_data;
               tccm_pkg::CSR_BG_INDEX:     bg_index_ff <= csr_data;
               tccm_pkg::CSR_PIXEL_FORMAT: pixel_format_ff <= csr_data[1:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            cursor_col_ff <= cursor_col_in;
            cursor_row_ff <= cursor_row_in;
         end
      end
   end

endmodule

FILE: design/tccm_cmd_queue.sv
module tccm_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tccm_pkg::cmd_type push_cmd,
   input  logic              pop,
   output tccm_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);

   tccm_pkg::cmd_type                 entry_ff [tccm_pkg::CMD_DEPTH];
   logic [tccm_pkg::CMD_PTR_W-1:0]    wr_ptr_ff;
   logic [tccm_pkg::CMD_PTR_W-1:0]    rd_ptr_ff;
   logic [tccm_pkg::CMD_CNT_W-1:0]    count_ff;
   logic                              do_push;
   logic                              do_pop;

   assign full    = (count_ff == tccm_pkg::CMD_CNT_W'(tccm_pkg::CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: design/tccm_back.sv
module tccm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  tccm_pkg::cmd_type cmd_head,
   output logic              cmd_pop,
   output logic              init_busy,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output tccm_pkg::rsp_type rsp
);

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_START = 7'b0000100,
      ST_COPY  = 7'b0001000,
      ST_BLANK = 7'b0010000,
      ST_CLEAR = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;
   tccm_pkg::cmd_type               cur_ff, cur_in;
   logic [tccm_pkg::LEN_W-1:0]      ptr_ff, ptr_in;
   logic                            rd_pend_ff, rd_pend_in;
   logic [tccm_pkg::ADDR_W-1:0]     wr_addr_ff, wr_addr_in;
   logic                            out_valid_ff, out_valid_in;
   tccm_pkg::rsp_type               out_ff, out_in;
   logic [7:0]                      rd_char_ff;
   logic [3:0]                      rd_color_ff;

   logic [7:0]                      char_mem  [tccm_pkg::STORE_DEPTH];
   logic [3:0]                      color_mem [tccm_pkg::STORE_DEPTH];

   logic                            we_char;
   logic                            we_color;
   logic [tccm_pkg::ADDR_W-1:0]     waddr;
   logic [7:0]                      wchar;
   logic [3:0]                      wcolor;
   logic                            re;
   logic [tccm_pkg::ADDR_W-1:0]     raddr;
   logic [tccm_pkg::LEN_W-1:0]      cols_ext;

   assign init_busy = (state_ff == ST_INIT);
   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;
   assign cols_ext  = tccm_pkg::LEN_W'(cur_ff.cols);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      ptr_in       = ptr_ff;
      rd_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      we_char      = 1'b0;
      we_color     = 1'b0;
      waddr        = ptr_ff[tccm_pkg::ADDR_W-1:0];
      wchar        = '0;
      wcolor       = '0;
      re           = 1'b0;
      raddr        = ptr_ff[tccm_pkg::ADDR_W-1:0];
      cmd_pop      = 1'b0;

      unique case (state_ff) inside
         ST_INIT: begin
            we_char  = 1'b1;
            we_color = 1'b1;
            ptr_in   = ptr_ff + 1'b1;
            if (ptr_ff == tccm_pkg::LEN_W'(tccm_pkg::STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd_head;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (cur_ff.do_write) begin
               we_char  = 1'b1;
               we_color = 1'b1;
               waddr    = cur_ff.addr;
               wchar    = cur_ff.rsp.cell_char;
               wcolor   = cur_ff.rsp.cell_color_index;
            end
            if (cur_ff.do_read) begin
               re    = 1'b1;
               raddr = cur_ff.addr;
            end
            if (cur_ff.do_scroll) begin
               state_in = ST_COPY;
               ptr_in   = cols_ext;
            end else if (cur_ff.do_clear) begin
               state_in = ST_CLEAR;
               ptr_in   = '0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            // read one row ahead, write the beat read last cycle one row up
            if (rd_pend_ff) begin
               we_char  = 1'b1;
               we_color = 1'b1;
               waddr    = wr_addr_ff;
               wchar    = rd_char_ff;
               wcolor   = rd_color_ff;
            end
            if (ptr_ff < cur_ff.len) begin
               re         = 1'b1;
               rd_pend_in = 1'b1;
               wr_addr_in = tccm_pkg::ADDR_W'(ptr_ff - cols_ext);
               ptr_in     = ptr_ff + 1'b1;
            end else begin
               state_in = ST_BLANK;
               ptr_in   = cur_ff.len - cols_ext;
            end
         end
         ST_BLANK, ST_CLEAR: begin
            // characters only, colors stay
            we_char = 1'b1;
            ptr_in  = ptr_ff + 1'b1;
            if (ptr_ff == cur_ff.len - 1'b1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_in       = cur_ff.rsp;
               if (cur_ff.do_read) begin
                  out_in.cell_char        = rd_char_ff;
                  out_in.cell_color_index = rd_color_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
            ptr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_char) begin
         char_mem[waddr] <= wchar;
      end
      if (we_color) begin
         color_mem[waddr] <= wcolor;
      end
      if (re) begin
         rd_char_ff  <= char_mem[raddr];
         rd_color_ff <= color_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ptr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      wr_addr_ff <= wr_addr_in;
      out_ff     <= out_in;
   end

   a_copy_behind_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY && rd_pend_ff) |-> (tccm_pkg::LEN_W'(wr_addr_ff) < ptr_ff))
      else $error("scroll copy write does not trail its read");

   a_sweep_in_area: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLANK || state_ff == ST_CLEAR) |-> (ptr_ff < cur_ff.len))
      else $error("character sweep left the area in use");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result appeared without a finished command");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == ST_START))
      else $error("command taken while a command was in progress");

endmodule

FILE: tb/text_console_cell_manager_core_tb.sv
module text_console_cell_manager_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 50000;
   localparam int PRINT_LIMIT  = 40;
   localparam logic [tccm_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   localparam logic [23:0] CONSOLE_PALETTE [16] = '{
      24'h000000, 24'h0000ff, 24'h00ff00, 24'h00ffff,
      24'hff0000, 24'hff00ff, 24'h808000, 24'hc0c0c0,
      24'h808080, 24'h000080, 24'hd9c4d1, 24'h96a48e,
      24'h800000, 24'h800080, 24'hffff00, 24'hffffff
   };

   typedef struct packed {
      tccm_pkg::op_type op;
      logic [7:0]       char_code;
      logic [7:0]       target_column;
      logic [6:0]       target_row;
   } console_cmd_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic                           req_full;
   logic [1:0]                     req_op = '0;
   logic [7:0]                     req_char_code = '0;
   logic [7:0]                     req_target_column = '0;
   logic [6:0]                     req_target_row = '0;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   logic                           rsp_cell_written;
   logic [6:0]                     rsp_cell_column;
   logic [5:0]                     rsp_cell_row;
   logic [7:0]                     rsp_cell_char;
   logic [3:0]                     rsp_cell_color_index;
   logic [23:0]                    rsp_fg_pixel;
   logic [23:0]                    rsp_bg_pixel;
   logic [6:0]                     rsp_cursor_column;
   logic [5:0]                     rsp_cursor_row;
   logic                           rsp_scrolled;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [tccm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]                     csr_data = '0;

   // console state as the predictor sees it
   logic [7:0]  glyph_mem [tccm_pkg::STORE_DEPTH];
   logic [3:0]  tint_mem [tccm_pkg::STORE_DEPTH];
   int unsigned cur_col = 0;
   int unsigned cur_row = 0;
   logic [7:0]  cfg_cols = tccm_pkg::RESET_COLUMN_COUNT;
   logic [6:0]  cfg_rows = tccm_pkg::RESET_ROW_COUNT;
   logic [7:0]  cfg_fg = tccm_pkg::RESET_FG_INDEX;
   logic [7:0]  cfg_bg = tccm_pkg::RESET_BG_INDEX;
   logic [1:0]  cfg_fmt = tccm_pkg::RESET_PIXEL_FORMAT;

   console_cmd_type    console_cmds_queued [$];
   tccm_pkg::rsp_type  console_results_due [$];
   console_cmd_type    held_cmd;
   tccm_pkg::rsp_type  seen_rsp;
   int                 send_gap = 0;
   int                 recv_gap = 0;
   int                 hold_left = 0;
   int                 results_seen = 0;
   int                 mismatches = 0;
   int                 idle_cycles = 0;
   bit                 no_idle = 1'b0;

   text_console_cell_manager_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_op               (req_op),
      .req_char_code        (req_char_code),
      .req_target_column    (req_target_column),
      .req_target_row       (req_target_row),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_cell_written     (rsp_cell_written),
      .rsp_cell_column      (rsp_cell_column),
      .rsp_cell_row         (rsp_cell_row),
      .rsp_cell_char        (rsp_cell_char),
      .rsp_cell_color_index (rsp_cell_color_index),
      .rsp_fg_pixel         (rsp_fg_pixel),
      .rsp_bg_pixel         (rsp_bg_pixel),
      .rsp_cursor_column    (rsp_cursor_column),
      .rsp_cursor_row       (rsp_cursor_row),
      .rsp_scrolled         (rsp_scrolled),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned fit_dim(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      return v > top ? top : v;
   endfunction

   function automatic int unsigned fit(int unsigned v, int unsigned n);
      return v >= n ? n - 1 : v;
   endfunction

   function automatic logic [23:0] packed_color(int unsigned idx);
      logic [23:0] c;
      c = CONSOLE_PALETTE[idx];
      case (cfg_fmt)
         tccm_pkg::PIX_RGB332: return ((c >> 16) & 24'h0000e0) | ((c >> 8) & 24'h000018) |
                                      (c & 24'h000003);
         tccm_pkg::PIX_RGB555: return ((c >> 9) & 24'h007c00) | ((c >> 6) & 24'h0003e0) |
                                      ((c >> 3) & 24'h00001f);
         tccm_pkg::PIX_RGB565: return ((c >> 8) & 24'h00f800) | ((c >> 5) & 24'h0007e0) |
                                      ((c >> 3) & 24'h00001f);
         default:              return c;
      endcase
   endfunction

   // applies one command to the console state and returns its result beat
   function automatic tccm_pkg::rsp_type run_console_cmd(console_cmd_type c);
      int unsigned       cols, rows, col, row, fgi, bgi, idx, len;
      bit                new_line;
      tccm_pkg::rsp_type r;
      cols = fit_dim(cfg_cols, tccm_pkg::MAX_COLUMNS);
      rows = fit_dim(cfg_rows, tccm_pkg::MAX_ROWS);
      len = cols * rows;
      col = fit(cur_col, cols);
      row = fit(cur_row, rows);
      fgi = cfg_fg > 15 ? 15 : cfg_fg;
      bgi = cfg_bg > 15 ? 15 : cfg_bg;
      new_line = 1'b0;
      r = '0;
      case (c.op)
         tccm_pkg::OP_PUT: begin
            if (c.char_code == tccm_pkg::NEWLINE_CODE) begin
               new_line = 1'b1;
            end else begin
               idx = row * cols + col;
               glyph_mem[idx] = c.char_code;
               tint_mem[idx] = 4'(fgi);
               r.cell_written = 1'b1;
               r.cell_column = 7'(col);
               r.cell_row = 6'(row);
               r.cell_char = c.char_code;
               r.cell_color_index = 4'(fgi);
               col++;
               if (col >= cols) new_line = 1'b1;
            end
            if (new_line) begin
               col = 0;
               row++;
               if (row >= rows) begin
                  // colors move with the text, bottom row keeps its colors
                  row = rows - 1;
                  for (int unsigned i = cols; i < len; i++) begin
                     glyph_mem[i - cols] = glyph_mem[i];
                     tint_mem[i - cols] = tint_mem[i];
                  end
                  for (int unsigned i = len - cols; i < len; i++) glyph_mem[i] = '0;
                  r.scrolled = 1'b1;
               end
            end
         end
         tccm_pkg::OP_LOCATE: begin
            col = fit(c.target_column, cols);
            row = fit(c.target_row, rows);
         end
         tccm_pkg::OP_READ: begin
            r.cell_column = 7'(fit(c.target_column, cols));
            r.cell_row = 6'(fit(c.target_row, rows));
            idx = r.cell_row * cols + r.cell_column;
            r.cell_char = glyph_mem[idx];
            r.cell_color_index = tint_mem[idx];
         end
         default: begin
            for (int unsigned i = 0; i < len; i++) glyph_mem[i] = '0;
         end
      endcase
      cur_col = col;
      cur_row = row;
      r.fg_pixel = packed_color(fgi);
      r.bg_pixel = packed_color(bgi);
      r.cursor_column = 7'(col);
      r.cursor_row = 6'(row);
      return r;
   endfunction

   task automatic flag_mismatch(string msg);
      if (mismatches < PRINT_LIMIT) $display("%0t: mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
         flag_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                 results_seen, name, got, want));
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full)
            console_results_due.push_back(run_console_cmd(held_cmd));
         if (!req_push || !req_full) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (console_cmds_queued.size() == 0) begin
               req_push <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 2);
               req_push <= 1'b0;
            end else begin
               held_cmd = console_cmds_queued.pop_front();
               req_push <= 1'b1;
               req_op <= held_cmd.op;
               req_char_code <= held_cmd.char_code;
               req_target_column <= held_cmd.target_column;
               req_target_row <= held_cmd.target_row;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         recv_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen_rsp.cell_written = rsp_cell_written;
            seen_rsp.cell_column = rsp_cell_column;
            seen_rsp.cell_row = rsp_cell_row;
            seen_rsp.cell_char = rsp_cell_char;
            seen_rsp.cell_color_index = rsp_cell_color_index;
            seen_rsp.fg_pixel = rsp_fg_pixel;
            seen_rsp.bg_pixel = rsp_bg_pixel;
            seen_rsp.cursor_column = rsp_cursor_column;
            seen_rsp.cursor_row = rsp_cursor_row;
            seen_rsp.scrolled = rsp_scrolled;
            if (console_results_due.size() == 0) begin
               flag_mismatch($sformatf("result beat %0d with nothing expected", results_seen));
            end else begin
               tccm_pkg::rsp_type want;
               want = console_results_due.pop_front();
               check_field("cell_written", seen_rsp.cell_written, want.cell_written);
               check_field("cell_column", seen_rsp.cell_column, want.cell_column);
               check_field("cell_row", seen_rsp.cell_row, want.cell_row);
               check_field("cell_char", seen_rsp.cell_char, want.cell_char);
               check_field("cell_color_index", seen_rsp.cell_color_index,
                           want.cell_color_index);
               check_field("fg_pixel", seen_rsp.fg_pixel, want.fg_pixel);
               check_field("bg_pixel", seen_rsp.bg_pixel, want.bg_pixel);
               check_field("cursor_column", seen_rsp.cursor_column, want.cursor_column);
               check_field("cursor_row", seen_rsp.cursor_row, want.cursor_row);
               check_field("scrolled", seen_rsp.scrolled, want.scrolled);
            end
            results_seen++;
            // long hold-off so the command side backs up
            if (results_seen == 500 || results_seen == 900) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_pop <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            recv_gap = $urandom_range(0, 2);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic add_cmd(tccm_pkg::op_type op, logic [7:0] ch, logic [7:0] tc,
                          logic [6:0] tr);
      console_cmd_type c;
      c.op = op;
      c.char_code = ch;
      c.target_column = tc;
      c.target_row = tr;
      console_cmds_queued.push_back(c);
   endtask

   task automatic add_random(int count, int clear_pct);
      console_cmd_type c;
      int unsigned     cols, rows;
      int              pick;
      cols = fit_dim(cfg_cols, tccm_pkg::MAX_COLUMNS);
      rows = fit_dim(cfg_rows, tccm_pkg::MAX_ROWS);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         c.char_code = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 2))
            0: begin
               c.target_column = 8'($urandom_range(0, 255));
               c.target_row = 7'($urandom_range(0, 127));
            end
            1: begin
               c.target_column = 8'($urandom_range(0, cols - 1));
               c.target_row = 7'($urandom_range(0, rows - 1));
            end
            default: begin
               // bottom right corner, or one past the last column
               c.target_column = 8'(cols - 1 + $urandom_range(0, 1));
               c.target_row = 7'(rows - 1);
            end
         endcase
         if (pick < clear_pct) begin
            c.op = tccm_pkg::OP_CLEAR;
         end else if (pick < 55) begin
            c.op = tccm_pkg::OP_PUT;
            if ($urandom_range(0, 6) == 0) c.char_code = tccm_pkg::NEWLINE_CODE;
         end else if (pick < 72) begin
            c.op = tccm_pkg::OP_LOCATE;
         end else begin
            c.op = tccm_pkg::OP_READ;
         end
         console_cmds_queued.push_back(c);
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (console_cmds_queued.size() != 0 || req_push || console_results_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // expects to be called right after a rising edge; leaves csr_valid high
   task automatic write_csr(logic [tccm_pkg::CSR_IDX_W-1:0] idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tccm_pkg::CSR_COLUMN_COUNT: cfg_cols = value;
         tccm_pkg::CSR_ROW_COUNT:    cfg_rows = value[6:0];
         tccm_pkg::CSR_FG_INDEX:     cfg_fg = value;
         tccm_pkg::CSR_BG_INDEX:     cfg_bg = value;
         tccm_pkg::CSR_PIXEL_FORMAT: cfg_fmt = value[1:0];
         default: ;
      endcase
   endtask

   task automatic set_console(logic [7:0] cols, logic [7:0] rows, logic [7:0] fg,
                              logic [7:0] bg, logic [1:0] fmt);
      wait_idle();
      @(posedge clock);
      write_csr(tccm_pkg::CSR_COLUMN_COUNT, cols);
      write_csr(tccm_pkg::CSR_ROW_COUNT, rows);
      write_csr(tccm_pkg::CSR_FG_INDEX, fg);
      write_csr(tccm_pkg::CSR_BG_INDEX, bg);
      write_csr(tccm_pkg::CSR_PIXEL_FORMAT, {6'd0, fmt});
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      for (int i = 0; i < tccm_pkg::STORE_DEPTH; i++) begin
         glyph_mem[i] = '0;
         tint_mem[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, put at the last column wraps and scrolls
      add_cmd(tccm_pkg::OP_PUT, 8'h48, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_READ, 8'd0, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_LOCATE, 8'd0, 8'd200, 7'd100);
      add_cmd(tccm_pkg::OP_PUT, 8'h78, 8'd0, 7'd0);

      set_console(8'd5, 8'd3, 8'd200, 8'd9, tccm_pkg::PIX_RGB332);
      add_cmd(tccm_pkg::OP_PUT, 8'h00, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_PUT, 8'hff, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_PUT, 8'h55, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_PUT, 8'haa, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_PUT, 8'h7e, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_PUT, tccm_pkg::NEWLINE_CODE, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_PUT, tccm_pkg::NEWLINE_CODE, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_READ, 8'd0, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_READ, 8'd0, 8'hff, 7'h7f);
      add_cmd(tccm_pkg::OP_LOCATE, 8'd0, 8'd3, 7'd1);
      add_cmd(tccm_pkg::OP_PUT, 8'h71, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_CLEAR, 8'd0, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_READ, 8'd0, 8'd3, 7'd1);
      add_cmd(tccm_pkg::OP_LOCATE, 8'd0, 8'hff, 7'h7f);

      // screen shrinks under the cursor
      set_console(8'd2, 8'd1, 8'd16, 8'd255, tccm_pkg::PIX_RGB555);
      add_cmd(tccm_pkg::OP_PUT, 8'h5a, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_PUT, tccm_pkg::NEWLINE_CODE, 8'd0, 7'd0);
      add_cmd(tccm_pkg::OP_READ, 8'd0, 8'hff, 7'h7f);

      set_console(8'd8, 8'd4, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 15)),
                  tccm_pkg::PIX_RGB555);
      add_random(250, 5);

      set_console(8'd1, 8'd1, 8'd0, 8'd255, tccm_pkg::PIX_RGB565);
      add_random(100, 5);

      set_console(8'd0, 8'd0, 8'd15, 8'd16, tccm_pkg::PIX_RGB888);
      @(posedge clock);
      write_csr(CSR_SPARE, 8'ha5);
      csr_valid <= 1'b0;
      @(negedge clock);
      no_idle = 1'b1;
      add_random(60, 5);

      set_console(8'd17, 8'd6, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  tccm_pkg::PIX_RGB332);
      no_idle = 1'b0;
      add_random(300, 5);

      // widest screen: clear and scroll walk the whole store, so few commands
      set_console(8'd255, 8'd127, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 15)),
                  tccm_pkg::PIX_RGB565);
      add_random(40, 2);

      set_console(8'd128, 8'd64, 8'd255, 8'd0, tccm_pkg::PIX_RGB555);
      add_random(20, 3);

      set_console(tccm_pkg::RESET_COLUMN_COUNT, {1'b0, tccm_pkg::RESET_ROW_COUNT},
                  tccm_pkg::RESET_FG_INDEX, tccm_pkg::RESET_BG_INDEX,
                  tccm_pkg::RESET_PIXEL_FORMAT);
      add_random(200, 3);

      set_console(8'd3, 8'd2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  2'($urandom_range(0, 3)));
      no_idle = 1'b1;
      add_random(400, 5);

      wait_idle();
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
design/tccm_pkg.sv
design/tccm_front.sv
design/tccm_cmd_queue.sv
design/tccm_back.sv
design/text_console_cell_manager_core.sv
tb/text_console_cell_manager_core_tb.sv
